/* sv/rgse_pkg.sv */
`timescale 1ns / 1ps
package rgse_pkg;

	localparam int RADIOTEXT_BYTES = 64;
	localparam int RT_ROWS = RADIOTEXT_BYTES / 4;
	localparam int CFG_W = 38;

	typedef logic [3:0][15:0] group_t;

	typedef struct packed {
		logic   valid;
		group_t grp;
	} grp_beat_t;

	typedef enum logic [2:0] {
		CFG_STATION = 3'd0,
		CFG_FLAGS   = 3'd1,
		CFG_ECC     = 3'd2,
		CFG_LIC     = 3'd3,
		CFG_PIN     = 3'd4,
		CFG_PTYN    = 3'd5,
		CFG_RTPLUS  = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		TXT_PS   = 2'd0,
		TXT_RT   = 2'd1,
		TXT_PTYN = 2'd2
	} txt_sel_t;

	typedef enum logic [2:0] {
		GK_PS,
		GK_RT,
		GK_PTYN1,
		GK_PTYN2,
		GK_EXT,
		GK_RTP_ANN,
		GK_RTP_TAG
	} group_kind_t;

	typedef enum logic [1:0] {
		EXT_ECC,
		EXT_LIC,
		EXT_PIN
	} ext_kind_t;

	localparam logic [15:0] GTYPE_1A  = 16'h1000;
	localparam logic [15:0] GTYPE_2A  = 16'h2000;
	localparam logic [15:0] GTYPE_3A  = 16'h3000;
	localparam logic [15:0] GTYPE_10A = 16'hA000;
	localparam logic [15:0] GTYPE_12A = 16'hC000;
	localparam logic [15:0] LIC_TAG   = 16'h3000;
	localparam logic [15:0] RTP_AID   = 16'h4BD7;

	// syndrome column of each data bit: x^(k+10) mod g(x), bit 15 first
	localparam logic [15:0][9:0] CRC_COL = {
		10'h077, 10'h2E7, 10'h3AF, 10'h30B, 10'h359, 10'h370, 10'h1B8, 10'h0DC,
		10'h06E, 10'h037, 10'h2C7, 10'h3BF, 10'h303, 10'h35D, 10'h372, 10'h1B9
	};

	function automatic logic [9:0] check_word(input logic [15:0] d);
		logic [9:0] r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			if (d[k]) r = r ^ CRC_COL[k];
		end
		return r;
	endfunction

	function automatic logic [9:0] offset_word(input logic [1:0] pos);
		logic [9:0] w;
		case (pos)
			2'd0: w = 10'h0FC;
			2'd1: w = 10'h198;
			2'd2: w = 10'h168;
			default: w = 10'h1B4;
		endcase
		return w;
	endfunction

endpackage

/* sv/rds_group_scheduler_encoder_core.sv */
`timescale 1ns / 1ps
// channel   handshake              payload
// input     push / full            operation, text_select, text_index, text_byte
// result    empty / pop            block_position, block_data, check_bits, last_block
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A text write yields no beat; a group request yields four beats A..D, one per
// cycle while pop is held, after staging, the queue and the block register.
// The block serializer loads the next group as the last block of the current one is popped.
// The input keeps accepting while the two-group queue and staging stage have room.
// Reset clears schedule state and most config; text stores hold garbage until written.
module rds_group_scheduler_encoder_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        operation,
	input  logic [1:0]                  text_select,
	input  logic [5:0]                  text_index,
	input  logic [7:0]                  text_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  block_position,
	output logic [15:0]                 block_data,
	output logic [9:0]                  check_bits,
	output logic                        last_block,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [rgse_pkg::CFG_W-1:0]  cfg_data
);

	rgse_pkg::grp_beat_t beat;
	rgse_pkg::group_t    q_data;
	logic                q_full, q_empty, q_rd;

	assign cfg_ready = 1'b1;

	rgse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.text_select (text_select),
		.text_index  (text_index),
		.text_byte   (text_byte),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.beat        (beat)
	);

	rgse_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (beat),
		.full    (q_full),
		.rd      (q_rd),
		.empty   (q_empty),
		.rd_data (q_data)
	);

	rgse_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_data         (q_data),
		.q_rd           (q_rd),
		.pop            (pop),
		.empty          (empty),
		.block_position (block_position),
		.block_data     (block_data),
		.check_bits     (check_bits),
		.last_block     (last_block)
	);

endmodule

/* sv/rgse_front.sv */
`timescale 1ns / 1ps
module rgse_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         operation,
	input  logic [1:0]                   text_select,
	input  logic [5:0]                   text_index,
	input  logic [7:0]                   text_byte,
	input  logic                         cfg_valid,
	input  logic [2:0]                   cfg_index,
	input  logic [rgse_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         q_full,
	output rgse_pkg::grp_beat_t          beat
);

	logic [15:0] station_q;
	logic [14:0] flags_q;
	logic [8:0]  ecc_q;
	logic [8:0]  lic_q;
	logic [16:0] pin_q;
	logic [1:0]  ptyn_q;
	logic [37:0] rtp_q;

	logic [2:0] slot_q;
	logic [1:0] ps_seg_q;
	logic [3:0] rt_seg_q;
	logic [1:0] rot_q;

	logic [15:0] ps_row_q   [4];
	logic [31:0] ptyn_row_q [2];
	logic [31:0] rt_mem     [rgse_pkg::RT_ROWS];

	logic                   valid_s1;
	rgse_pkg::group_kind_t  kind_s1;
	rgse_pkg::ext_kind_t    ext_s1;
	logic [3:0]             seg_s1;
	logic [31:0]            text_s1;
	logic [31:0]            rt_s1;

	logic                   acc, acc_grp, acc_wr;
	rgse_pkg::group_kind_t  kind;
	rgse_pkg::ext_kind_t    ext_sel;
	logic [1:0]             rot_next;
	logic                   ecc_en, lic_en, pin_en;

	assign full    = valid_s1 & q_full;
	assign acc     = push & ~full;
	assign acc_grp = acc & operation;
	assign acc_wr  = acc & ~operation;

	assign ecc_en = ecc_q[8];
	assign lic_en = lic_q[8];
	assign pin_en = pin_q[16];

	always_comb begin
		if (ecc_en && lic_en) begin
			ext_sel  = rot_q[0] ? rgse_pkg::EXT_LIC : rgse_pkg::EXT_ECC;
			rot_next = {rot_q[0], ~rot_q[0]};
		end else begin
			rot_next = 2'd1;
			if (ecc_en) ext_sel = rgse_pkg::EXT_ECC;
			else if (lic_en) ext_sel = rgse_pkg::EXT_LIC;
			else ext_sel = rgse_pkg::EXT_PIN;
		end
	end

	always_comb begin
		if (rtp_q[37] && slot_q == 3'd6) kind = rgse_pkg::GK_RTP_ANN;
		else if (rtp_q[37] && slot_q == 3'd7) kind = rgse_pkg::GK_RTP_TAG;
		else if (slot_q == 3'd3 && (ecc_en || lic_en || pin_en)) kind = rgse_pkg::GK_EXT;
		else if (slot_q == 3'd4 || slot_q == 3'd5) kind = rgse_pkg::GK_RT;
		else if (ptyn_q[0] && slot_q == 3'd1) kind = rgse_pkg::GK_PTYN1;
		else if (ptyn_q[0] && ptyn_q[1] && slot_q == 3'd2) kind = rgse_pkg::GK_PTYN2;
		else kind = rgse_pkg::GK_PS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= 16'h1234;
			flags_q   <= 15'h0080;
			ecc_q     <= '0;
			lic_q     <= '0;
			pin_q     <= '0;
			ptyn_q    <= '0;
			rtp_q     <= '0;
		end else if (cfg_valid) begin
			case (rgse_pkg::cfg_idx_t'(cfg_index))
				rgse_pkg::CFG_STATION: station_q <= cfg_data[15:0];
				rgse_pkg::CFG_FLAGS:   flags_q   <= cfg_data[14:0];
				rgse_pkg::CFG_ECC:     ecc_q     <= cfg_data[8:0];
				rgse_pkg::CFG_LIC:     lic_q     <= cfg_data[8:0];
				rgse_pkg::CFG_PIN:     pin_q     <= cfg_data[16:0];
				rgse_pkg::CFG_PTYN:    ptyn_q    <= cfg_data[1:0];
				rgse_pkg::CFG_RTPLUS:  rtp_q     <= cfg_data[37:0];
				default: ;
			endcase
		end
	end

	// schedule state advances at group accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			ps_seg_q <= '0;
			rt_seg_q <= '0;
			rot_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc_grp | (valid_s1 & q_full);
			if (acc_grp) begin
				slot_q <= slot_q + 3'd1;
				case (kind)
					rgse_pkg::GK_PS:  ps_seg_q <= ps_seg_q + 2'd1;
					rgse_pkg::GK_RT:  rt_seg_q <= rt_seg_q + 4'd1;
					rgse_pkg::GK_EXT: rot_q    <= rot_next;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_wr) begin
			case (rgse_pkg::txt_sel_t'(text_select))
				rgse_pkg::TXT_PS: begin
					if (text_index[5:3] == 3'd0) begin
						if (text_index[0]) ps_row_q[text_index[2:1]][7:0] <= text_byte;
						else ps_row_q[text_index[2:1]][15:8] <= text_byte;
					end
				end
				rgse_pkg::TXT_RT:
					rt_mem[text_index[5:2]][{~text_index[1:0], 3'b000} +: 8] <= text_byte;
				rgse_pkg::TXT_PTYN: begin
					if (text_index[5:3] == 3'd0)
						ptyn_row_q[text_index[2]][{~text_index[1:0], 3'b000} +: 8] <= text_byte;
				end
				default: ;
			endcase
		end
	end

	// snapshot text at accept so later writes cannot reach this group
	always_ff @(posedge clk) begin
		if (acc_grp) begin
			kind_s1 <= kind;
			ext_s1  <= ext_sel;
			seg_s1  <= (kind == rgse_pkg::GK_RT) ? rt_seg_q : {2'b00, ps_seg_q};
			text_s1 <= (kind == rgse_pkg::GK_PS) ? {16'h0000, ps_row_q[ps_seg_q]}
			                                     : ptyn_row_q[slot_q == 3'd2];
			if (kind == rgse_pkg::GK_RT) rt_s1 <= rt_mem[rt_seg_q];
		end
	end

	logic [15:0] base;
	logic [3:0]  di;
	logic        ab;
	always_comb begin
		base = {5'b00000, flags_q[5], flags_q[4:0], 5'b00000};
		di   = flags_q[11:8];
		case (flags_q[13:12])
			2'd1: ab = 1'b1;
			2'd2: ab = flags_q[14];
			default: ab = 1'b0;
		endcase
		beat.valid  = valid_s1;
		beat.grp[0] = station_q;
		beat.grp[1] = '0;
		beat.grp[2] = '0;
		beat.grp[3] = '0;
		case (kind_s1)
			rgse_pkg::GK_RTP_ANN: begin
				beat.grp[1] = rgse_pkg::GTYPE_3A | base | {11'd0, rtp_q[36:32]};
				beat.grp[3] = rgse_pkg::RTP_AID;
			end
			rgse_pkg::GK_RTP_TAG: begin
				beat.grp[1] = rgse_pkg::GTYPE_12A | base | {11'd0, rtp_q[36:32]};
				beat.grp[2] = rtp_q[31:16];
				beat.grp[3] = rtp_q[15:0];
			end
			rgse_pkg::GK_EXT: begin
				beat.grp[1] = rgse_pkg::GTYPE_1A | base;
				beat.grp[3] = pin_en ? pin_q[15:0] : 16'h0000;
				case (ext_s1)
					rgse_pkg::EXT_ECC: beat.grp[2] = {8'h00, ecc_q[7:0]};
					rgse_pkg::EXT_LIC: beat.grp[2] = rgse_pkg::LIC_TAG | {8'h00, lic_q[7:0]};
					default:           beat.grp[2] = station_q;
				endcase
			end
			rgse_pkg::GK_RT: begin
				beat.grp[1] = rgse_pkg::GTYPE_2A | base | {11'd0, ab, seg_s1};
				beat.grp[2] = rt_s1[31:16];
				beat.grp[3] = rt_s1[15:0];
			end
			rgse_pkg::GK_PTYN1: begin
				beat.grp[1] = rgse_pkg::GTYPE_10A | base;
				beat.grp[2] = text_s1[31:16];
				beat.grp[3] = text_s1[15:0];
			end
			rgse_pkg::GK_PTYN2: begin
				beat.grp[1] = rgse_pkg::GTYPE_10A | base | 16'h0001;
				beat.grp[2] = text_s1[31:16];
				beat.grp[3] = text_s1[15:0];
			end
			default: begin
				beat.grp[1] = base | {11'd0, flags_q[6], flags_q[7], di[2'd3 - seg_s1[1:0]],
				                      seg_s1[1:0]};
				beat.grp[3] = text_s1[15:0];
			end
		endcase
	end

endmodule

/* sv/rgse_fifo.sv */
`timescale 1ns / 1ps
module rgse_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rgse_pkg::grp_beat_t  wr,
	output logic                 full,
	input  logic                 rd,
	output logic                 empty,
	output rgse_pkg::group_t     rd_data
);

	rgse_pkg::group_t ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_wr   = wr.valid & ~full;
	assign do_rd   = rd & ~empty;
	assign rd_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) ent_q[wr_ptr_q] <= wr.grp;
	end

endmodule

/* sv/rgse_back.sv */
`timescale 1ns / 1ps
module rgse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  rgse_pkg::group_t  q_data,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output logic [1:0]        block_position,
	output logic [15:0]       block_data,
	output logic [9:0]        check_bits,
	output logic              last_block
);

	rgse_pkg::group_t grp_q;
	logic [1:0]       idx_q;
	logic             busy_q;
	logic             take, at_end;

	assign take   = pop & busy_q;
	assign at_end = take & (idx_q == 2'd3);
	assign q_rd   = ~q_empty & (~busy_q | at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (q_rd) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else begin
				if (at_end) busy_q <= 1'b0;
				if (take) idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) grp_q <= q_data;
	end

	assign empty          = ~busy_q;
	assign block_position = idx_q;
	assign block_data     = grp_q[idx_q];
	assign check_bits     = rgse_pkg::check_word(block_data) ^ rgse_pkg::offset_word(idx_q);
	assign last_block     = idx_q == 2'd3;

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		take && idx_q != 2'd3 |=> busy_q && idx_q == $past(idx_q) + 2'd1)
		else $error("block index did not advance after a beat");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		at_end && q_empty |=> !busy_q)
		else $error("result still shown after last block with no group queued");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !pop |=> busy_q && $stable(idx_q) && $stable(block_data))
		else $error("stalled block changed");

	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> busy_q && idx_q == 2'd0)
		else $error("new group does not start at block A");

endmodule
